// ===== hw/rtl/cet_pkg.sv =====
// ----------------------------------------------------------------------------
// cet_pkg
// Shared widths, operation and status codes and beat structs of the
// counting event table.
// ----------------------------------------------------------------------------
package cet_pkg;

  localparam int ENTRIES    = 64;
  localparam int ENTRY_W    = 6;
  localparam int INDEX_SPAN = 1 << ENTRY_W;
  // only entries the index field can name are ever used
  localparam int USABLE     = (ENTRIES < INDEX_SPAN) ? ENTRIES : INDEX_SPAN;
  localparam int ADDR_W     = $clog2(USABLE);
  localparam int COUNT_W    = 64;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 3;

  localparam logic [COUNT_W-1:0] ERR_COUNT = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_SET   = 3'd2,
    KIND_INC   = 3'd3,
    KIND_GET   = 3'd4,
    KIND_TEST  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_SPACE    = 3'd1,
    ST_INVALID     = 3'd2,
    ST_INTERRUPTED = 3'd3,
    ST_NOT_REACHED = 3'd4
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] entry;
    logic [COUNT_W-1:0] success_value;
    logic [COUNT_W-1:0] failure_value;
    logic [COUNT_W-1:0] threshold;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] given_index;
    logic [COUNT_W-1:0] success_count;
    logic [COUNT_W-1:0] failure_count;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] succ;
    logic [COUNT_W-1:0] fail;
  } wr_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [ADDR_W-1:0] addr;
  } mark_upd_t;

endpackage

// ===== hw/rtl/cet_marks.sv =====
// ----------------------------------------------------------------------------
// cet_marks
// Allocated marks of the table with a lowest-free-entry priority encoder.
// ----------------------------------------------------------------------------
module cet_marks (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [cet_pkg::ADDR_W-1:0] rd_addr_i,
  input  cet_pkg::mark_upd_t       upd_i,
  output logic                     rd_mark_o,
  output logic                     free_found_o,
  output logic [cet_pkg::ADDR_W-1:0] free_idx_o
);

  logic [cet_pkg::USABLE-1:0] marks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else begin
      if (upd_i.set) begin
        marks_q[upd_i.addr] <= 1'b1;
      end
      if (upd_i.clr) begin
        marks_q[upd_i.addr] <= 1'b0;
      end
    end
  end

  assign rd_mark_o = marks_q[rd_addr_i];

  // walk down so the lowest free entry wins
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = cet_pkg::USABLE - 1; i >= 0; i--) begin
      if (!marks_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = cet_pkg::ADDR_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/cet_counts.sv =====
// ----------------------------------------------------------------------------
// cet_counts
// Success and failure count memory: one write and one registered read a
// cycle, with a bypass for a read that meets the write of the same edge.
// ----------------------------------------------------------------------------
module cet_counts (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cet_pkg::ADDR_W-1:0] rd_addr_i,
  input  cet_pkg::wr_t               wr_i,
  output logic [cet_pkg::COUNT_W-1:0] succ_o,
  output logic [cet_pkg::COUNT_W-1:0] fail_o
);

  logic [cet_pkg::COUNT_W-1:0] succ_mem [cet_pkg::USABLE];
  logic [cet_pkg::COUNT_W-1:0] fail_mem [cet_pkg::USABLE];
  logic [cet_pkg::COUNT_W-1:0] succ_rd_q, fail_rd_q;
  logic [cet_pkg::COUNT_W-1:0] succ_fwd_q, fail_fwd_q;
  logic                        fwd_hit_q, fwd_hit_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      succ_mem[wr_i.addr] <= wr_i.succ;
      fail_mem[wr_i.addr] <= wr_i.fail;
    end
    succ_rd_q  <= succ_mem[rd_addr_i];
    fail_rd_q  <= fail_mem[rd_addr_i];
    succ_fwd_q <= wr_i.succ;
    fail_fwd_q <= wr_i.fail;
  end

  // memory returns old data when the same entry is written on the read edge
  assign fwd_hit_d = wr_i.en && (wr_i.addr == rd_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  assign succ_o = fwd_hit_q ? succ_fwd_q : succ_rd_q;
  assign fail_o = fwd_hit_q ? fail_fwd_q : fail_rd_q;

endmodule

// ===== hw/rtl/cet_exec.sv =====
// ----------------------------------------------------------------------------
// cet_exec
// Operation decode and count arithmetic for the command held in the input
// register: builds the result beat, the count write and the mark update.
// ----------------------------------------------------------------------------
module cet_exec (
  input  logic                        vld_i,
  input  cet_pkg::cmd_t               cmd_i,
  input  logic                        mark_i,
  input  logic                        free_found_i,
  input  logic [cet_pkg::ADDR_W-1:0]  free_idx_i,
  input  logic [cet_pkg::COUNT_W-1:0] succ_i,
  input  logic [cet_pkg::COUNT_W-1:0] fail_i,
  output logic [cet_pkg::ADDR_W-1:0]  addr_o,
  output cet_pkg::res_t               res_o,
  output cet_pkg::wr_t                wr_o,
  output cet_pkg::mark_upd_t          mark_o
);

  logic                        in_range;
  logic                        entry_ok;
  logic                        inc_fail;
  logic [cet_pkg::COUNT_W-1:0] add_a, add_b, inc_sum, test_sum;

  assign addr_o   = cmd_i.entry[cet_pkg::ADDR_W-1:0];
  assign in_range = {1'b0, cmd_i.entry} < (cet_pkg::ENTRY_W + 1)'(cet_pkg::USABLE);
  assign entry_ok = in_range && mark_i;

  // one adder serves both counts of an increment
  assign inc_fail = cmd_i.failure_value != '0;
  assign add_a    = inc_fail ? fail_i : succ_i;
  assign add_b    = inc_fail ? cmd_i.failure_value : cmd_i.success_value;
  assign inc_sum  = add_a + add_b;
  assign test_sum = succ_i + fail_i;

  always_comb begin
    res_o  = '{status: cet_pkg::ST_INVALID, default: '0};
    wr_o   = '{addr: addr_o, succ: succ_i, fail: fail_i, default: '0};
    mark_o = '{addr: addr_o, default: '0};
    unique case (cmd_i.kind)
      cet_pkg::KIND_ALLOC: begin
        if (free_found_i) begin
          res_o.status      = cet_pkg::ST_OK;
          res_o.given_index = cet_pkg::ENTRY_W'(free_idx_i);
          wr_o.en           = 1'b1;
          wr_o.addr         = free_idx_i;
          wr_o.succ         = '0;
          wr_o.fail         = '0;
          mark_o.set        = 1'b1;
          mark_o.addr       = free_idx_i;
        end else begin
          res_o.status = cet_pkg::ST_NO_SPACE;
        end
      end
      cet_pkg::KIND_FREE: begin
        if (entry_ok) begin
          res_o.status = cet_pkg::ST_OK;
          wr_o.en      = 1'b1;
          wr_o.succ    = cet_pkg::ERR_COUNT;
          wr_o.fail    = cet_pkg::ERR_COUNT;
          mark_o.clr   = 1'b1;
        end
      end
      cet_pkg::KIND_SET: begin
        if (entry_ok) begin
          res_o.status = cet_pkg::ST_OK;
          wr_o.en      = 1'b1;
          wr_o.succ    = cmd_i.success_value;
          wr_o.fail    = cmd_i.failure_value;
        end
      end
      cet_pkg::KIND_INC: begin
        if (entry_ok && !(inc_fail && cmd_i.success_value != '0)) begin
          res_o.status = cet_pkg::ST_OK;
          wr_o.en      = 1'b1;
          if (inc_fail) begin
            wr_o.fail = inc_sum;
          end else begin
            wr_o.succ = inc_sum;
          end
        end
      end
      cet_pkg::KIND_GET: begin
        if (entry_ok) begin
          res_o.status        = cet_pkg::ST_OK;
          res_o.success_count = succ_i;
          res_o.failure_count = fail_i;
        end
      end
      cet_pkg::KIND_TEST: begin
        if (entry_ok) begin
          res_o.success_count = succ_i;
          res_o.failure_count = fail_i;
          if (succ_i == cet_pkg::ERR_COUNT || fail_i == cet_pkg::ERR_COUNT) begin
            res_o.status = cet_pkg::ST_INTERRUPTED;
          end else if (fail_i != '0 || test_sum >= cmd_i.threshold) begin
            res_o.status = cet_pkg::ST_OK;
          end else begin
            res_o.status = cet_pkg::ST_NOT_REACHED;
          end
        end
      end
      default: begin
        res_o.status = cet_pkg::ST_INVALID;
      end
    endcase
    if (!vld_i) begin
      wr_o.en    = 1'b0;
      mark_o.set = 1'b0;
      mark_o.clr = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/counting_event_table.sv =====
// ----------------------------------------------------------------------------
// counting_event_table
// Table of success/failure event counter pairs with allocated marks.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (kind_i, entry_i, success_value_i, failure_value_i,
//   threshold_i) is taken at a rising edge with start high and busy low.
//   busy stays low, so a command can be issued every cycle.
//   Each command gives exactly one result beat: status_o, given_index_o,
//   success_count_o and failure_count_o are valid for the single cycle in
//   which done_o is high; done_o rises once the command has passed the
//   input register and the result register.
//   Throughput is one command per cycle; the count memory is read on the
//   command edge and written on the next one, and a bypass register covers
//   back-to-back commands on the same entry.
//   Reset clears all allocated marks; counts of an entry are defined from
//   its alloc on. No result beat is lost after reset release.
//   The receiver cannot stall: results are not held past their cycle.
// ----------------------------------------------------------------------------
module counting_event_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [cet_pkg::KIND_W-1:0]     kind_i,
  input  logic [cet_pkg::ENTRY_W-1:0]    entry_i,
  input  logic [cet_pkg::COUNT_W-1:0]    success_value_i,
  input  logic [cet_pkg::COUNT_W-1:0]    failure_value_i,
  input  logic [cet_pkg::COUNT_W-1:0]    threshold_i,
  output logic                           done_o,
  output logic [cet_pkg::STATUS_W-1:0]   status_o,
  output logic [cet_pkg::ENTRY_W-1:0]    given_index_o,
  output logic [cet_pkg::COUNT_W-1:0]    success_count_o,
  output logic [cet_pkg::COUNT_W-1:0]    failure_count_o
);

  cet_pkg::cmd_t              cmd_q;
  logic                       vld_q;
  cet_pkg::res_t              res_q, res_d;
  logic                       done_q;
  logic                       accept;
  logic                       rd_mark, free_found;
  logic [cet_pkg::ADDR_W-1:0] free_idx, exec_addr;
  logic [cet_pkg::COUNT_W-1:0] succ_rd, fail_rd;
  cet_pkg::wr_t               wr;
  cet_pkg::mark_upd_t         mark_upd;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= '{kind: kind_i, entry: entry_i, success_value: success_value_i,
                 failure_value: failure_value_i, threshold: threshold_i};
    end
  end

  cet_marks u_marks (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (exec_addr),
    .upd_i        (mark_upd),
    .rd_mark_o    (rd_mark),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  // count read is issued straight from the command beat
  cet_counts u_counts (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (entry_i[cet_pkg::ADDR_W-1:0]),
    .wr_i      (wr),
    .succ_o    (succ_rd),
    .fail_o    (fail_rd)
  );

  cet_exec u_exec (
    .vld_i        (vld_q),
    .cmd_i        (cmd_q),
    .mark_i       (rd_mark),
    .free_found_i (free_found),
    .free_idx_i   (free_idx),
    .succ_i       (succ_rd),
    .fail_i       (fail_rd),
    .addr_o       (exec_addr),
    .res_o        (res_d),
    .wr_o         (wr),
    .mark_o       (mark_upd)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign given_index_o   = res_q.given_index;
  assign success_count_o = res_q.success_count;
  assign failure_count_o = res_q.failure_count;

endmodule

// ===== hw/rtl/cet_checker.sv =====
// ----------------------------------------------------------------------------
// cet_checker
// Port-level checks of the counting event table, bound to the top level.
// ----------------------------------------------------------------------------
module cet_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [cet_pkg::STATUS_W-1:0] status_o,
  input logic [cet_pkg::ENTRY_W-1:0]  given_index_o,
  input logic [cet_pkg::COUNT_W-1:0]  success_count_o,
  input logic [cet_pkg::COUNT_W-1:0]  failure_count_o
);

  // every command beat gives exactly one result beat, after the input and result registers
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(rst_ni, 2)) |-> (done_o == $past(start && !busy, 2)))
    else $error("result beat does not match command beat two cycles earlier");

  // a handed-out index only comes with a clean alloc result
  a_alloc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && given_index_o != '0) |->
      (status_o == cet_pkg::ST_OK && success_count_o == '0 && failure_count_o == '0))
    else $error("alloc result carries counts or a bad status");

  a_interrupted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cet_pkg::ST_INTERRUPTED) |->
      (success_count_o == cet_pkg::ERR_COUNT || failure_count_o == cet_pkg::ERR_COUNT))
    else $error("interrupted without an error count");

  a_not_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cet_pkg::ST_NOT_REACHED) |-> (failure_count_o == '0))
    else $error("not reached with a nonzero failure count");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == cet_pkg::ST_INVALID || status_o == cet_pkg::ST_NO_SPACE)) |->
      (given_index_o == '0 && success_count_o == '0 && failure_count_o == '0))
    else $error("error result carries nonzero fields");

endmodule

bind counting_event_table cet_checker u_cet_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .given_index_o   (given_index_o),
  .success_count_o (success_count_o),
  .failure_count_o (failure_count_o)
);

// ===== sim/tb_counting_event_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_event_table
// Sends command beats to the counter table in random bursts, keeps a shadow
// copy of the table to predict every result beat and checks them in order.
// ----------------------------------------------------------------------------
module tb_counting_event_table;

  localparam logic [cet_pkg::COUNT_W-1:0] ALL_ONES = '1;
  localparam int RANDOM_CMDS = 450;
  localparam int SHOWN_MISMATCHES = 10;

  class counter_table_shadow;
    logic [cet_pkg::COUNT_W-1:0] success_tab [cet_pkg::USABLE];
    logic [cet_pkg::COUNT_W-1:0] failure_tab [cet_pkg::USABLE];
    bit                          live [cet_pkg::USABLE];
    cet_pkg::res_t               pending_replies [$];
    int unsigned                 mismatches;

    function void clear_table();
      for (int i = 0; i < cet_pkg::USABLE; i++) begin
        success_tab[i] = '0;
        failure_tab[i] = '0;
        live[i] = 1'b0;
      end
      pending_replies.delete();
      mismatches = 0;
    endfunction

    function void push_reply(cet_pkg::status_e st, logic [cet_pkg::ENTRY_W-1:0] idx,
                             logic [cet_pkg::COUNT_W-1:0] s,
                             logic [cet_pkg::COUNT_W-1:0] f);
      cet_pkg::res_t r;
      r.status = st;
      r.given_index = idx;
      r.success_count = s;
      r.failure_count = f;
      pending_replies.push_back(r);
    endfunction

    // predicts the reply of one accepted command and updates the table
    function void apply_command(logic [cet_pkg::KIND_W-1:0] kind,
                                logic [cet_pkg::ENTRY_W-1:0] entry,
                                logic [cet_pkg::COUNT_W-1:0] sv,
                                logic [cet_pkg::COUNT_W-1:0] fv,
                                logic [cet_pkg::COUNT_W-1:0] thr);
      logic [cet_pkg::COUNT_W-1:0] s;
      logic [cet_pkg::COUNT_W-1:0] f;
      logic [cet_pkg::COUNT_W-1:0] total;
      int found;
      found = -1;
      if (kind == cet_pkg::KIND_ALLOC) begin
        for (int i = 0; i < cet_pkg::USABLE; i++) begin
          if (found < 0 && !live[i]) found = i;
        end
        if (found < 0) begin
          push_reply(cet_pkg::ST_NO_SPACE, '0, '0, '0);
        end else begin
          live[found] = 1'b1;
          success_tab[found] = '0;
          failure_tab[found] = '0;
          push_reply(cet_pkg::ST_OK, found[cet_pkg::ENTRY_W-1:0], '0, '0);
        end
        return;
      end
      if (kind > cet_pkg::KIND_TEST || entry >= cet_pkg::USABLE || !live[entry]) begin
        push_reply(cet_pkg::ST_INVALID, '0, '0, '0);
        return;
      end
      s = success_tab[entry];
      f = failure_tab[entry];
      case (kind)
        cet_pkg::KIND_FREE: begin
          live[entry] = 1'b0;
          success_tab[entry] = ALL_ONES;
          failure_tab[entry] = ALL_ONES;
          push_reply(cet_pkg::ST_OK, '0, '0, '0);
        end
        cet_pkg::KIND_SET: begin
          success_tab[entry] = sv;
          failure_tab[entry] = fv;
          push_reply(cet_pkg::ST_OK, '0, '0, '0);
        end
        cet_pkg::KIND_INC: begin
          if (fv == '0) begin
            success_tab[entry] = s + sv;
            push_reply(cet_pkg::ST_OK, '0, '0, '0);
          end else if (sv == '0) begin
            failure_tab[entry] = f + fv;
            push_reply(cet_pkg::ST_OK, '0, '0, '0);
          end else begin
            push_reply(cet_pkg::ST_INVALID, '0, '0, '0);
          end
        end
        cet_pkg::KIND_GET: begin
          push_reply(cet_pkg::ST_OK, '0, s, f);
        end
        default: begin
          // sum wraps at 64 bits
          total = s + f;
          if (s == ALL_ONES || f == ALL_ONES) push_reply(cet_pkg::ST_INTERRUPTED, '0, s, f);
          else if (f != '0 || total >= thr) push_reply(cet_pkg::ST_OK, '0, s, f);
          else push_reply(cet_pkg::ST_NOT_REACHED, '0, s, f);
        end
      endcase
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES) $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    function void match_result(logic [cet_pkg::STATUS_W-1:0] st,
                               logic [cet_pkg::ENTRY_W-1:0] idx,
                               logic [cet_pkg::COUNT_W-1:0] s,
                               logic [cet_pkg::COUNT_W-1:0] f);
      cet_pkg::res_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected: st=%0d idx=%0d s=%h f=%h",
                                  st, idx, s, f));
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || idx !== want.given_index ||
          s !== want.success_count || f !== want.failure_count) begin
        report_mismatch($sformatf("exp st=%0d idx=%0d s=%h f=%h, got st=%0d idx=%0d s=%h f=%h",
                                  want.status, want.given_index, want.success_count,
                                  want.failure_count, st, idx, s, f));
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < cet_pkg::USABLE; i++) n += live[i];
      return n;
    endfunction

    // random allocated entry, or -1 when none is allocated
    function int pick_live();
      int ids [$];
      for (int i = 0; i < cet_pkg::USABLE; i++) if (live[i]) ids.push_back(i);
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function logic [cet_pkg::COUNT_W-1:0] success_of(int e);
      return success_tab[e];
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [cet_pkg::KIND_W-1:0]   kind_i;
  logic [cet_pkg::ENTRY_W-1:0]  entry_i;
  logic [cet_pkg::COUNT_W-1:0]  success_value_i;
  logic [cet_pkg::COUNT_W-1:0]  failure_value_i;
  logic [cet_pkg::COUNT_W-1:0]  threshold_i;
  logic                         done_o;
  logic [cet_pkg::STATUS_W-1:0] status_o;
  logic [cet_pkg::ENTRY_W-1:0]  given_index_o;
  logic [cet_pkg::COUNT_W-1:0]  success_count_o;
  logic [cet_pkg::COUNT_W-1:0]  failure_count_o;

  counter_table_shadow shadow = new();
  int burst_left;

  counting_event_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .entry_i         (entry_i),
    .success_value_i (success_value_i),
    .failure_value_i (failure_value_i),
    .threshold_i     (threshold_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .given_index_o   (given_index_o),
    .success_count_o (success_count_o),
    .failure_count_o (failure_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200us;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    if (done_o === 1'b1) shadow.match_result(status_o, given_index_o, success_count_o,
                                             failure_count_o);
  end

  // one command beat, then the sender's burst and gap bookkeeping
  task automatic send_cmd(logic [cet_pkg::KIND_W-1:0] kind,
                          logic [cet_pkg::ENTRY_W-1:0] entry,
                          logic [cet_pkg::COUNT_W-1:0] sv,
                          logic [cet_pkg::COUNT_W-1:0] fv,
                          logic [cet_pkg::COUNT_W-1:0] thr);
    int gap;
    start <= 1'b1;
    kind_i <= kind;
    entry_i <= entry;
    success_value_i <= sv;
    failure_value_i <= fv;
    threshold_i <= thr;
    do @(posedge clk_i); while (busy !== 1'b0);
    shadow.apply_command(kind, entry, sv, fv, thr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  function automatic logic [cet_pkg::COUNT_W-1:0] rand_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return ALL_ONES - 1;
      4: return 64'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [cet_pkg::KIND_W-1:0]  kind;
    logic [cet_pkg::ENTRY_W-1:0] entry;
    logic [cet_pkg::COUNT_W-1:0] sv;
    logic [cet_pkg::COUNT_W-1:0] fv;
    logic [cet_pkg::COUNT_W-1:0] thr;
    int roll;
    int pick;
    bit filling;

    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = '0;
    entry_i = '0;
    success_value_i = '0;
    failure_value_i = '0;
    threshold_i = '0;
    burst_left = 0;
    shadow.clear_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // operations on free entries and unknown kinds, then two allocs
    send_cmd(cet_pkg::KIND_GET, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_SET, 6'd63, ALL_ONES, ALL_ONES, ALL_ONES);
    send_cmd(3'd6, 6'd0, '0, '0, '0);
    send_cmd(3'd7, 6'd63, ALL_ONES, ALL_ONES, ALL_ONES);
    send_cmd(cet_pkg::KIND_ALLOC, 6'd63, '0, '0, '0);
    send_cmd(cet_pkg::KIND_ALLOC, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_GET, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd0, '0, '0, 64'd1);
    // success count wraps past all ones
    send_cmd(cet_pkg::KIND_SET, 6'd0, ALL_ONES - 1, '0, '0);
    send_cmd(cet_pkg::KIND_INC, 6'd0, 64'd5, '0, '0);
    send_cmd(cet_pkg::KIND_GET, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_INC, 6'd0, 64'd1, 64'd1, '0);
    send_cmd(cet_pkg::KIND_INC, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd0, '0, '0, 64'd4);
    send_cmd(cet_pkg::KIND_TEST, 6'd0, '0, '0, 64'd3);
    send_cmd(cet_pkg::KIND_INC, 6'd1, '0, ALL_ONES, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd1, '0, '0, '0);
    send_cmd(cet_pkg::KIND_SET, 6'd1, '0, 64'd1, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd1, '0, '0, ALL_ONES);
    send_cmd(cet_pkg::KIND_SET, 6'd0, ALL_ONES, '0, '0);
    send_cmd(cet_pkg::KIND_TEST, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_FREE, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_GET, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_ALLOC, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_GET, 6'd0, '0, '0, '0);
    send_cmd(cet_pkg::KIND_FREE, 6'd1, '0, '0, '0);
    send_cmd(cet_pkg::KIND_FREE, 6'd1, '0, '0, '0);

    // alternate between filling the table up and draining it
    filling = 1'b1;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(0, 99);
      if (filling ? roll < 60 : roll < 5) kind = cet_pkg::KIND_ALLOC;
      else if (filling ? roll < 65 : roll < 60) kind = cet_pkg::KIND_FREE;
      else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) kind = cet_pkg::KIND_SET;
        else if (roll < 55) kind = cet_pkg::KIND_INC;
        else if (roll < 72) kind = cet_pkg::KIND_GET;
        else if (roll < 95) kind = cet_pkg::KIND_TEST;
        else kind = 3'($urandom_range(6, 7));
      end
      pick = shadow.pick_live();
      if (pick >= 0 && $urandom_range(0, 99) < 85) entry = pick[cet_pkg::ENTRY_W-1:0];
      else entry = 6'($urandom_range(0, 63));
      sv = rand_count();
      fv = rand_count();
      if (kind == cet_pkg::KIND_SET && $urandom_range(0, 1) == 0) fv = '0;
      if (kind == cet_pkg::KIND_INC) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: fv = '0;
          4, 5, 6, 7: sv = '0;
          8: begin
            sv = '0;
            fv = '0;
          end
          default: begin
            if (sv == '0) sv = 64'd1;
            if (fv == '0) fv = {$urandom, $urandom} | 64'd1;
          end
        endcase
      end
      // thresholds around the success count hit the compare boundary
      case ($urandom_range(0, 3))
        0: thr = rand_count();
        1: thr = shadow.success_of(entry);
        2: thr = shadow.success_of(entry) + 1;
        default: thr = shadow.success_of(entry) - 1;
      endcase
      send_cmd(kind, entry, sv, fv, thr);
      if (filling && shadow.live_count() == cet_pkg::USABLE && $urandom_range(0, 3) == 0)
        filling = 1'b0;
      else if (!filling && shadow.live_count() <= 3) filling = 1'b1;
    end

    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
